FILE: hdl/rmpi_pkg.sv
`default_nettype none
package rmpi_pkg;

   localparam int MAX_TASKS = 32;
   localparam int PRIO_BITS = 8;
   localparam int NEST_MAX  = 255;

   localparam int ID_W   = 5;
   localparam int FPRI_W = 8;
   localparam int IDX_W  = $clog2(MAX_TASKS);
   localparam int WC_W   = $clog2(MAX_TASKS + 1);
   localparam int NEST_W = $clog2(NEST_MAX + 1);

   typedef enum logic {
      KIND_TAKE = 1'b0,
      KIND_GIVE = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_GRANTED    = 4'd0,
      ST_NESTED     = 4'd1,
      ST_BLOCKED    = 4'd2,
      ST_WAIT_FULL  = 4'd3,
      ST_NEST_OVF   = 4'd4,
      ST_IGNORED    = 4'd5,
      ST_STILL_HELD = 4'd6,
      ST_HANDED_OFF = 4'd7,
      ST_FREED      = 4'd8
   } status_type;

   typedef struct packed {
      kind_type          kind;
      logic [ID_W-1:0]   task_id;
      logic [FPRI_W-1:0] task_prio;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   owner_task;
      logic              boost_valid;
      logic [FPRI_W-1:0] boost_prio;
      logic              restore_valid;
      logic [FPRI_W-1:0] restore_prio;
      logic              wake_valid;
      logic [ID_W-1:0]   wake_task;
      logic              block_caller;
      logic              preempt_request;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]      id;
      logic [PRIO_BITS-1:0] prio;
   } waiter_type;

endpackage
`default_nettype wire

FILE: hdl/rmpi_core.sv
`default_nettype none
module rmpi_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic             inherit_enable,
   input  wire rmpi_pkg::req_type item,
   output rmpi_pkg::rsp_type     result
);
   import rmpi_pkg::*;

   logic                 owner_valid_ff, owner_valid_in;
   logic [ID_W-1:0]      owner_id_ff, owner_id_in;
   logic [PRIO_BITS-1:0] owner_base_ff, owner_base_in;
   logic [PRIO_BITS-1:0] owner_cur_ff, owner_cur_in;
   logic [NEST_W-1:0]    nest_count_ff, nest_count_in;
   logic [PRIO_BITS-1:0] inherited_ff, inherited_in;
   logic [WC_W-1:0]      wait_count_ff, wait_count_in;
   waiter_type           wait_stack_ff [MAX_TASKS];

   logic [PRIO_BITS-1:0] prio;
   logic [WC_W-1:0]      top_pos;
   waiter_type           top_entry;
   logic                 push;

   assign prio      = PRIO_BITS'(item.task_prio);
   assign top_pos   = wait_count_ff - WC_W'(1);
   assign top_entry = wait_stack_ff[top_pos[IDX_W-1:0]];

   always_comb begin
      owner_valid_in = owner_valid_ff;
      owner_id_in    = owner_id_ff;
      owner_base_in  = owner_base_ff;
      owner_cur_in   = owner_cur_ff;
      nest_count_in  = nest_count_ff;
      inherited_in   = inherited_ff;
      wait_count_in  = wait_count_ff;
      push           = 1'b0;
      result         = '0;
      result.status  = ST_GRANTED;

      if (item.kind == KIND_TAKE) begin
         if (!owner_valid_ff) begin
            owner_valid_in = 1'b1;
            owner_id_in    = item.task_id;
            owner_base_in  = prio;
            owner_cur_in   = prio;
            nest_count_in  = NEST_W'(1);
            result.status  = ST_GRANTED;
         end else if (owner_id_ff == item.task_id) begin
            if (nest_count_ff >= NEST_W'(NEST_MAX)) begin
               result.status = ST_NEST_OVF;
            end else begin
               nest_count_in = nest_count_ff + NEST_W'(1);
               result.status = ST_NESTED;
            end
         end else if (wait_count_ff >= WC_W'(MAX_TASKS)) begin
            result.status = ST_WAIT_FULL;
         end else begin
            push                = 1'b1;
            wait_count_in       = wait_count_ff + WC_W'(1);
            result.status       = ST_BLOCKED;
            result.block_caller = 1'b1;
            if (inherit_enable && (prio > owner_cur_ff)) begin
               if (prio > inherited_ff) begin
                  inherited_in = prio;
               end
               owner_cur_in           = prio;
               result.boost_valid     = 1'b1;
               result.boost_prio      = FPRI_W'(prio);
               result.owner_task      = owner_id_ff;
               result.preempt_request = 1'b1;
            end
         end
      end else begin
         if (!owner_valid_ff || (owner_id_ff != item.task_id)) begin
            result.status = ST_IGNORED;
         end else if (nest_count_ff > NEST_W'(1)) begin
            nest_count_in = nest_count_ff - NEST_W'(1);
            result.status = ST_STILL_HELD;
         end else begin
            if (inherit_enable) begin
               owner_cur_in         = owner_base_ff;
               result.restore_valid = 1'b1;
               result.restore_prio  = FPRI_W'(owner_base_ff);
               result.owner_task    = owner_id_ff;
            end
            if (wait_count_ff != '0) begin
               wait_count_in          = top_pos;
               owner_id_in            = top_entry.id;
               owner_base_in          = top_entry.prio;
               owner_cur_in           = top_entry.prio;
               nest_count_in          = NEST_W'(1);
               result.wake_valid      = 1'b1;
               result.wake_task       = top_entry.id;
               result.preempt_request = 1'b1;
               result.status          = ST_HANDED_OFF;
            end else begin
               owner_valid_in = 1'b0;
               nest_count_in  = '0;
               result.status  = ST_FREED;
            end
            inherited_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_valid_ff <= 1'b0;
         owner_id_ff    <= '0;
         owner_base_ff  <= '0;
         owner_cur_ff   <= '0;
         nest_count_ff  <= '0;
         inherited_ff   <= '0;
         wait_count_ff  <= '0;
      end else if (step) begin
         owner_valid_ff <= owner_valid_in;
         owner_id_ff    <= owner_id_in;
         owner_base_ff  <= owner_base_in;
         owner_cur_ff   <= owner_cur_in;
         nest_count_ff  <= nest_count_in;
         inherited_ff   <= inherited_in;
         wait_count_ff  <= wait_count_in;
      end
   end

   // waiter stack, no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (step && push) begin
         wait_stack_ff[wait_count_ff[IDX_W-1:0]] <= '{id: item.task_id, prio: prio};
      end
   end

endmodule
`default_nettype wire

FILE: hdl/recursive_mutex_priority_inherit.sv
`default_nettype none
// Recursive mutex with priority inheritance. Each req beat is a take or a give
// from one task; each produces exactly one rsp beat with the status and any
// boost, restore or wake-up it caused. A beat is captured in an input register,
// decided combinationally against the owner state and the waiter stack, and the
// result lands in an output register. A new beat can be taken every cycle while
// the output register is empty or rsp_ready is high, the rate being set by the
// state update loop. The waiter stack (32 entries of id and priority) is held in
// flops with no clearing pass, so the block is ready right after reset. The csr
// write beat sets inherit_enable (reset 1) and is meant to be written while idle.
module recursive_mutex_priority_inherit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rmpi_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rmpi_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_data
);
   import rmpi_pkg::*;

   logic    inherit_ff;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type step_result;
   logic    advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inherit_ff <= 1'b1;
      end else if (csr_valid) begin
         inherit_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_result;
      end
   end

   rmpi_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .inherit_enable (inherit_ff),
      .item           (in_data_ff),
      .result         (step_result)
   );

endmodule
`default_nettype wire
